>>> design/rmte_pkg.sv
// Shared types, constants and helpers for the rotation-matrix-to-Euler block.
// Used by the square-root cells, the CORDIC cells and the top level.
package rmte_pkg;

  localparam int unsigned CW     = 36;  // CORDIC x/y width
  localparam int unsigned ZW     = 20;  // CORDIC angle width, Q16 radians
  localparam int unsigned SQW    = 30;  // square-root working width
  localparam int unsigned SQ_CELLS = 15;
  localparam int unsigned TAB_LEN  = 24;
  localparam int unsigned LANES    = 5;

  localparam logic signed [ZW-1:0] PI_Q16      = ZW'(205887);
  localparam logic signed [15:0]   PI_Q12      = 16'sd12868;
  localparam logic signed [15:0]   HALF_PI_Q12 = 16'sd6434;
  localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

  typedef enum logic [2:0] {
    LANE_YAW_A   = 3'd0,
    LANE_ROLL_A  = 3'd1,
    LANE_YAW_B   = 3'd2,
    LANE_ROLL_B  = 3'd3,
    LANE_PITCH   = 3'd4
  } lane_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m13;
    logic signed [15:0] m21;
    logic signed [15:0] m31;
    logic signed [15:0] m32;
    logic signed [15:0] m33;
    logic               gim_neg;
    logic               gim_pos;
  } side_t;

  typedef struct packed {
    logic gim_neg;
    logic gim_pos;
  } gim_t;

  function automatic logic signed [ZW-1:0] ang_tab(input int unsigned i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = ZW'(51472);
      1:  t = ZW'(30386);
      2:  t = ZW'(16055);
      3:  t = ZW'(8150);
      4:  t = ZW'(4091);
      5:  t = ZW'(2047);
      6:  t = ZW'(1024);
      7:  t = ZW'(512);
      8:  t = ZW'(256);
      9:  t = ZW'(128);
      10: t = ZW'(64);
      11: t = ZW'(32);
      12: t = ZW'(16);
      13: t = ZW'(8);
      14: t = ZW'(4);
      15: t = ZW'(2);
      16: t = ZW'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic signed [16:0] neg17(input logic signed [15:0] a);
    logic signed [16:0] e;
    e = {a[15], a};
    return -e;
  endfunction

  function automatic logic signed [16:0] ext17(input logic signed [15:0] a);
    return {a[15], a};
  endfunction

  // Quadrant fold and scaling ahead of the first CORDIC step.
  function automatic lane_t lane_init(input logic signed [16:0] y,
                                      input logic signed [16:0] x);
    lane_t              l;
    logic signed [17:0] xe;
    logic signed [17:0] ye;
    xe = {x[16], x};
    ye = {y[16], y};
    l.z = '0;
    if (x[16]) begin
      xe  = -xe;
      ye  = -ye;
      l.z = y[16] ? -PI_Q16 : PI_Q16;
    end
    l.x    = {{(CW-34){xe[17]}}, xe, 16'b0};
    l.y    = {{(CW-34){ye[17]}}, ye, 16'b0};
    l.zero = (x == '0) && (y == '0);
    return l;
  endfunction

endpackage

>>> design/rmte_sqrt_cell.sv
// One step of the bit-pair integer square root, registered.
// Depends on rmte_pkg.
module rmte_sqrt_cell import rmte_pkg::*; #(
  parameter int unsigned K = 0
) (
  input  logic clk_i,
  input  sq_t  sq_i,
  output sq_t  sq_o
);

  localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

  sq_t            sq_d;
  sq_t            sq_q;
  logic [SQW-1:0] trial;

  always_comb begin
    trial = sq_i.res + BIT;
    if (sq_i.n >= trial) begin
      sq_d.n   = sq_i.n - trial;
      sq_d.res = (sq_i.res >> 1) + BIT;
    end else begin
      sq_d.n   = sq_i.n;
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

>>> design/rmte_cordic_cell.sv
// One vectoring-mode CORDIC micro-rotation for one lane, registered.
// Depends on rmte_pkg.
module rmte_cordic_cell import rmte_pkg::*; #(
  parameter int unsigned I = 0
) (
  input  logic  clk_i,
  input  lane_t lane_i,
  output lane_t lane_o
);

  lane_t lane_d;
  lane_t lane_q;

  always_comb begin
    lane_d = lane_i;
    if (I < TAB_LEN) begin
      if (!lane_i.y[CW-1]) begin
        lane_d.x = lane_i.x + (lane_i.y >>> I);
        lane_d.y = lane_i.y - (lane_i.x >>> I);
        lane_d.z = lane_i.z + ang_tab(I);
      end else begin
        lane_d.x = lane_i.x - (lane_i.y >>> I);
        lane_d.y = lane_i.y + (lane_i.x >>> I);
        lane_d.z = lane_i.z - ang_tab(I);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

>>> design/rotation_matrix_to_euler.sv
// Z-Y-X Euler angles (both solutions) from a rotation matrix.
// Depends on rmte_pkg, rmte_sqrt_cell and rmte_cordic_cell.
//
// Usage:
//   Drive the seven matrix entries (Q1.14) with start_i high for one cycle;
//   a beat is taken on every clock edge where start_i is high and busy_o low.
//   busy_o is always low: a new matrix may enter every cycle.
//   The six angles (Q3.12 radians) are registered at the output,
//   held for exactly one cycle and marked by valid_o; they must be taken then.
//   Throughput is one matrix per cycle. Each beat passes the input register,
//   15 square-root cells for cos(pitch), the quadrant-fold register,
//   CORDIC_STAGES rotation cells (five lanes side by side) and the output
//   register.
//   Reset clears only the valid pipeline; beats in flight are dropped.
//   At gimbal lock (m31 at or beyond +-1.0) yaw is 0, pitch is +-pi/2 and
//   both solutions carry the same roll.
module rotation_matrix_to_euler import rmte_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m13_i,
  input  logic signed [15:0] m21_i,
  input  logic signed [15:0] m31_i,
  input  logic signed [15:0] m32_i,
  input  logic signed [15:0] m33_i,
  output logic               valid_o,
  output logic signed [15:0] yaw_a_o,
  output logic signed [15:0] pitch_a_o,
  output logic signed [15:0] roll_a_o,
  output logic signed [15:0] yaw_b_o,
  output logic signed [15:0] pitch_b_o,
  output logic signed [15:0] roll_b_o
);

  localparam int unsigned LAT = CORDIC_STAGES + SQ_CELLS + 3;

  // valid pipeline
  logic [LAT-1:0] vld_q;
  logic           acc;

  assign busy_o = 1'b0;
  assign acc    = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  assign valid_o = vld_q[LAT-1];

  // input register: clamp m31 and form 1 - m31^2
  side_t              side_d;
  logic signed [31:0] m31_sq;
  sq_t                sq_in_d;
  side_t              side_q [SQ_CELLS+1];
  sq_t                sq_c   [SQ_CELLS+1];

  always_comb begin
    side_d.m11     = m11_i;
    side_d.m12     = m12_i;
    side_d.m13     = m13_i;
    side_d.m21     = m21_i;
    side_d.m32     = m32_i;
    side_d.m33     = m33_i;
    side_d.gim_neg = (m31_i <= -ONE_Q14);
    side_d.gim_pos = (m31_i >= ONE_Q14);
    if (side_d.gim_neg) begin
      side_d.m31 = -ONE_Q14;
    end else if (side_d.gim_pos) begin
      side_d.m31 = ONE_Q14;
    end else begin
      side_d.m31 = m31_i;
    end
    m31_sq      = 32'(side_d.m31) * 32'(side_d.m31);
    sq_in_d.n   = SQW'(32'sd268435456 - m31_sq);
    sq_in_d.res = '0;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    sq_c[0]   <= sq_in_d;
  end

  // square-root chain, side data travels alongside
  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
    rmte_sqrt_cell #(.K(SQ_CELLS - 1 - k)) u_cell (
      .clk_i (clk_i),
      .sq_i  (sq_c[k]),
      .sq_o  (sq_c[k+1])
    );
    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_q[k];
    end
  end

  // quadrant fold into the five lanes
  side_t              sd;
  logic signed [16:0] cos_p;
  lane_t              pre_d [LANES];
  lane_t              lane_c [CORDIC_STAGES+1][LANES];
  gim_t               gim_q  [CORDIC_STAGES+1];

  assign sd    = side_q[SQ_CELLS];
  assign cos_p = {1'b0, sq_c[SQ_CELLS].res[15:0]};

  always_comb begin
    pre_d[LANE_YAW_A]  = lane_init(ext17(sd.m21), ext17(sd.m11));
    pre_d[LANE_YAW_B]  = lane_init(neg17(sd.m21), neg17(sd.m11));
    pre_d[LANE_ROLL_B] = lane_init(neg17(sd.m32), neg17(sd.m33));
    pre_d[LANE_PITCH]  = lane_init(ext17(sd.m31), cos_p);
    if (sd.gim_neg) begin
      pre_d[LANE_ROLL_A] = lane_init(ext17(sd.m12), ext17(sd.m13));
    end else if (sd.gim_pos) begin
      pre_d[LANE_ROLL_A] = lane_init(neg17(sd.m12), neg17(sd.m13));
    end else begin
      pre_d[LANE_ROLL_A] = lane_init(ext17(sd.m32), ext17(sd.m33));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      lane_c[0][l] <= pre_d[l];
    end
    gim_q[0].gim_neg <= sd.gim_neg;
    gim_q[0].gim_pos <= sd.gim_pos;
  end

  // CORDIC rows
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_row
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      rmte_cordic_cell #(.I(s)) u_cell (
        .clk_i  (clk_i),
        .lane_i (lane_c[s][l]),
        .lane_o (lane_c[s+1][l])
      );
    end
    always_ff @(posedge clk_i) begin
      gim_q[s+1] <= gim_q[s];
    end
  end

  // rounding to Q3.12 and result selection
  logic signed [15:0] ang [LANES];
  logic signed [ZW-1:0] zr [LANES];
  gim_t               gl;
  logic signed [15:0] pa;
  logic signed [15:0] yaw_a_d, pitch_a_d, roll_a_d, yaw_b_d, pitch_b_d, roll_b_d;
  logic signed [15:0] yaw_a_q, pitch_a_q, roll_a_q, yaw_b_q, pitch_b_q, roll_b_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      zr[l]  = lane_c[CORDIC_STAGES][l].z + ZW'(8);
      ang[l] = lane_c[CORDIC_STAGES][l].zero ? 16'sd0 : zr[l][19:4];
    end
    gl = gim_q[CORDIC_STAGES];
    pa = -ang[LANE_PITCH];
    if (gl.gim_neg || gl.gim_pos) begin
      yaw_a_d   = '0;
      yaw_b_d   = '0;
      pitch_a_d = gl.gim_neg ? HALF_PI_Q12 : -HALF_PI_Q12;
      pitch_b_d = pitch_a_d;
      roll_a_d  = ang[LANE_ROLL_A];
      roll_b_d  = ang[LANE_ROLL_A];
    end else begin
      yaw_a_d   = ang[LANE_YAW_A];
      yaw_b_d   = ang[LANE_YAW_B];
      pitch_a_d = pa;
      pitch_b_d = PI_Q12 - pa;
      roll_a_d  = ang[LANE_ROLL_A];
      roll_b_d  = ang[LANE_ROLL_B];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_a_q   <= yaw_a_d;
    pitch_a_q <= pitch_a_d;
    roll_a_q  <= roll_a_d;
    yaw_b_q   <= yaw_b_d;
    pitch_b_q <= pitch_b_d;
    roll_b_q  <= roll_b_d;
  end

  assign yaw_a_o   = yaw_a_q;
  assign pitch_a_o = pitch_a_q;
  assign roll_a_o  = roll_a_q;
  assign yaw_b_o   = yaw_b_q;
  assign pitch_b_o = pitch_b_q;
  assign roll_b_o  = roll_b_q;

  // checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT valid_o)
    else $error("accepted beat did not emerge after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, LAT))
    else $error("result strobe without matching input beat");

  a_pitch_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (pitch_b_o == 16'(PI_Q12 - pitch_a_o)) ||
                (pitch_a_o == pitch_b_o && roll_a_o == roll_b_o &&
                 yaw_a_o == 16'sd0 && yaw_b_o == 16'sd0))
    else $error("second pitch inconsistent with first");

endmodule
